[rtl/core/b64e_pkg.sv]
package b64e_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CharW  = 7;
  localparam int unsigned SextW  = 6;
  localparam int unsigned JobMax = 4;
  localparam int unsigned IdxW   = $clog2(JobMax);
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [CharW-1:0] CharUpperA = 7'h41;
  localparam logic [CharW-1:0] CharPlus   = 7'h2B;
  localparam logic [CharW-1:0] CharSlash  = 7'h2F;
  localparam logic [CharW-1:0] CharPad    = 7'h3D;
  // offsets from the sextet value to ASCII for the lower-case and digit ranges
  localparam logic [CharW-1:0] OffsLower  = 7'd71;
  localparam logic [CharW-1:0] OffsDigit  = 7'd4;

  localparam logic [SextW-1:0] SextLowerA = 6'd26;
  localparam logic [SextW-1:0] SextDigit0 = 6'd52;
  localparam logic [SextW-1:0] SextPlus   = 6'd62;

  // position within the 3-byte group
  typedef enum logic [2:0] {
    POS_0 = 3'b001,
    POS_1 = 3'b010,
    POS_2 = 3'b100
  } pos_e;

  // one decoded byte: up to four characters, index of the final one,
  // and whether that final one closes the message
  typedef struct packed {
    logic [JobMax-1:0][CharW-1:0] chars;
    logic [IdxW-1:0]              last_idx;
    logic                         eot;
  } job_t;

  function automatic logic [CharW-1:0] b64e_alpha(input logic [SextW-1:0] v);
    logic [CharW-1:0] c;
    c = {1'b0, v};
    if (v < SextLowerA) begin
      return c + CharUpperA;
    end else if (v < SextDigit0) begin
      return c + OffsLower;
    end else if (v < SextPlus) begin
      return c - OffsDigit;
    end else if (v == SextPlus) begin
      return CharPlus;
    end else begin
      return CharSlash;
    end
  endfunction

endpackage

[rtl/core/b64e_if.sv]
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       end_of_text;

  modport source (output valid, output out_char, output end_of_text, input ready);
  modport sink   (input valid, input out_char, input end_of_text, output ready);
endinterface

[rtl/core/b64e_front.sv]
module b64e_front import b64e_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             is_last_i,
  output job_t             job_o
);

  pos_e       pos_q, pos_d;
  logic [3:0] left_q, left_d;

  always_comb begin
    job_o          = '0;
    job_o.chars[2] = CharPad;
    job_o.chars[3] = CharPad;
    pos_d          = POS_0;
    left_d         = '0;
    unique case (pos_q)
      POS_1: begin
        job_o.chars[0] = b64e_alpha({left_q[1:0], data_byte_i[7:4]});
        if (is_last_i) begin
          job_o.chars[1] = b64e_alpha({data_byte_i[3:0], 2'b00});
          job_o.last_idx = IdxW'(2);
          job_o.eot      = 1'b1;
        end else begin
          pos_d  = POS_2;
          left_d = data_byte_i[3:0];
        end
      end
      POS_2: begin
        job_o.chars[0] = b64e_alpha({left_q, data_byte_i[7:6]});
        job_o.chars[1] = b64e_alpha(data_byte_i[5:0]);
        job_o.last_idx = IdxW'(1);
        job_o.eot      = is_last_i;
      end
      default: begin
        job_o.chars[0] = b64e_alpha(data_byte_i[7:2]);
        if (is_last_i) begin
          job_o.chars[1] = b64e_alpha({data_byte_i[1:0], 4'b0000});
          job_o.last_idx = IdxW'(3);
          job_o.eot      = 1'b1;
        end else begin
          pos_d  = POS_1;
          left_d = {2'b00, data_byte_i[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_0;
      left_q <= '0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      left_q <= left_d;
    end
  end

endmodule

[rtl/core/b64e_queue.sv]
module b64e_queue import b64e_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic avail_o,
  output job_t job_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign avail_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPtrW'(1);
      if (pop_i)  rd_q <= rd_q + QPtrW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

[rtl/core/b64e_back.sv]
module b64e_back import b64e_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  input  job_t             job_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [CharW-1:0] out_char_o,
  output logic             end_of_text_o
);

  job_t            cur_q;
  logic            cur_vld_q;
  logic [IdxW-1:0] idx_q;
  logic            out_vld_q;
  logic [CharW-1:0] char_q;
  logic            eot_q;
  logic            out_free, emit, done;

  assign out_free = !out_vld_q || ready_i;
  assign emit     = cur_vld_q && out_free;
  assign done     = emit && (idx_q == cur_q.last_idx);
  assign pop_o    = avail_i && (!cur_vld_q || done);

  assign valid_o       = out_vld_q;
  assign out_char_o    = char_q;
  assign end_of_text_o = eot_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= job_i;
    if (emit) begin
      char_q <= cur_q.chars[idx_q];
      eot_q  <= done && cur_q.eot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (pop_o) begin
        cur_vld_q <= 1'b1;
      end else if (done) begin
        cur_vld_q <= 1'b0;
      end
      if (done || !cur_vld_q) begin
        idx_q <= '0;
      end else if (emit) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

endmodule

[rtl/core/base64_stream_encoder_core.sv]
// Base64 stream encoder, standard alphabet with '=' padding.
//
// in_i  : raw byte words (data_byte, is_last); is_last marks the final byte
//         of a message. Every message carries at least one byte.
// out_o : one ASCII character per word (out_char); end_of_text is set on the
//         final character of the encoded message, after any padding.
//
// A byte gives one character at group positions 0 and 1, two at position 2;
// a last byte gives four (position 0), three (1) or two (2) with padding.
// The first character of a byte passes the job queue, the back end's
// current-job register and the output register. Throughput: out_o moves
// one character per cycle while out_o.ready holds; the input byte rate
// follows it, set by the character serialiser in the back end.
// The front end decodes each byte into a character job in the cycle it is
// taken; a 2-entry job queue lets it keep taking bytes while out_o stalls.
// in_i.ready drops only once that queue is full.
// Reset: asynchronous, active low; group position and queue are cleared,
// out_o.valid goes low, and the next byte starts a fresh group.
module base64_stream_encoder_core import b64e_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64e_byte_if.sink   in_i,
  b64e_char_if.source out_o
);

  logic q_full, q_avail, q_pop, in_accept;
  job_t front_job, head_job;

  // front end takes a word whenever the queue has room
  assign in_i.ready = !q_full;
  assign in_accept  = in_i.valid && !q_full;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (in_i.data_byte),
    .is_last_i   (in_i.is_last),
    .job_o       (front_job)
  );

  b64e_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .job_o   (head_job)
  );

  // back end: serialises one job, one character per cycle while out_o is not
  // stalled, into the output register
  b64e_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (q_avail),
    .job_i         (head_job),
    .pop_o         (q_pop),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .out_char_o    (out_o.out_char),
    .end_of_text_o (out_o.end_of_text)
  );

endmodule

[rtl/core/b64e_checker.sv]
module b64e_checker import b64e_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CharW-1:0] out_char_i,
  input logic             out_eot_i
);

  logic [1:0] cnt_q;
  logic       acc, legal;

  assign acc   = out_valid_i && out_ready_i;
  assign legal = (out_char_i >= 7'h41 && out_char_i <= 7'h5A) ||
                 (out_char_i >= 7'h61 && out_char_i <= 7'h7A) ||
                 (out_char_i >= 7'h30 && out_char_i <= 7'h39) ||
                 out_char_i == CharPlus || out_char_i == CharSlash ||
                 out_char_i == CharPad;

  // characters taken since the last message end, modulo four
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (acc) begin
      cnt_q <= out_eot_i ? 2'd0 : cnt_q + 2'd1;
    end
  end

  // checked at the following edge, after the asynchronous reset has cleared the output
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i) && $stable(out_eot_i))
    else $error("stalled word changed");

  a_legal: assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_i |-> legal)
    else $error("character outside alphabet");

  a_eot_quad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && out_eot_i |-> cnt_q == 2'd3)
    else $error("message length not a multiple of four");

  a_pad_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && out_char_i == CharPad |-> cnt_q == 2'd2 || cnt_q == 2'd3)
    else $error("padding in wrong place");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.out_char),
  .out_eot_i   (out_o.end_of_text)
);

[tb/tb_base64_stream_encoder_core.sv]
module tb_base64_stream_encoder_core;
  import b64e_pkg::*;

  // one character word as it leaves out_o
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             eot;
  } b64_char_t;

  // Directed row. Where typed is set, text holds the characters read straight
  // off the encoding (first character in the top byte) and n_chars how many.
  // Other rows are left to the encoder model below.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [2:0]  n_chars;
    logic [31:0] text;
  } dir_row_t;

  localparam int NumDir    = 25;
  localparam int RandBytes = 255;
  // stretch of the random part with no idling on either side
  localparam int SteadyLo  = NumDir + 110;
  localparam int SteadyHi  = NumDir + 190;

  localparam logic [8*64-1:0] B64Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  localparam dir_row_t DirRows [NumDir] = '{
    // single-byte messages at the extremes: two data characters, two pads
    '{8'h00, 1'b1, 1'b1, 3'd4, "AA=="},
    '{8'hFF, 1'b1, 1'b1, 3'd4, "/w=="},
    // two-byte message: one pad
    '{8'hFF, 1'b0, 1'b1, 3'd1, "/   "},
    '{8'hFF, 1'b1, 1'b1, 3'd3, "/8= "},
    // full groups, no padding, then a two-byte message with one pad
    '{8'hFF, 1'b0, 1'b1, 3'd1, "/   "},
    '{8'hFF, 1'b0, 1'b1, 3'd1, "/   "},
    '{8'hFF, 1'b1, 1'b1, 3'd2, "//  "},
    '{8'h00, 1'b0, 1'b1, 3'd1, "A   "},
    '{8'h00, 1'b0, 1'b1, 3'd1, "A   "},
    '{8'h00, 1'b1, 1'b1, 3'd2, "AA  "},
    '{8'h00, 1'b0, 1'b1, 3'd1, "A   "},
    '{8'h00, 1'b1, 1'b1, 3'd3, "AA= "},
    // mixed patterns, left to the model
    '{8'h4D, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h61, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h6E, 1'b1, 1'b0, 3'd0, 32'h0},
    '{8'h80, 1'b1, 1'b0, 3'd0, 32'h0},
    '{8'h01, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hFE, 1'b1, 1'b0, 3'd0, 32'h0},
    '{8'h55, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hAA, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h0F, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hF0, 1'b1, 1'b0, 3'd0, 32'h0},
    '{8'h3C, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'hC3, 1'b0, 1'b0, 3'd0, 32'h0},
    '{8'h5A, 1'b1, 1'b0, 3'd0, 32'h0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  b64e_byte_if byte_if ();
  b64e_char_if char_if ();

  base64_stream_encoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (char_if)
  );

  always #2 clk_i = ~clk_i;

  // encoder model state: place in the 3-byte group and the input bits
  // still owed to the next character
  logic [1:0] grp_pos;
  logic [3:0] spare_bits;
  b64_char_t  pred_chars [4];

  b64_char_t  pending_chars [$];
  b64_char_t  exp_c;

  bit steady_run;
  int fail_count;
  int bytes_sent;
  int msgs_sent;
  int chars_checked;

  function automatic logic [CharW-1:0] sextet_to_ascii(input logic [5:0] v);
    int unsigned k;
    k = 63 - int'(v);
    return B64Alphabet[8*k +: CharW];
  endfunction

  // Works out the characters one byte completes, in order, into pred_chars.
  // Returns how many. A last byte pads the group out and restarts it.
  function automatic int encode_byte(input logic [7:0] d, input logic l);
    int n;
    n = 0;
    if (grp_pos == 2'd1) begin
      pred_chars[0] = '{sextet_to_ascii({spare_bits[1:0], d[7:4]}), 1'b0};
      if (l) begin
        pred_chars[1] = '{sextet_to_ascii({d[3:0], 2'b00}), 1'b0};
        pred_chars[2] = '{CharPad, 1'b1};
        n = 3;
        grp_pos = 2'd0;
        spare_bits = 4'd0;
      end else begin
        n = 1;
        spare_bits = d[3:0];
        grp_pos = 2'd2;
      end
    end else if (grp_pos == 2'd2) begin
      pred_chars[0] = '{sextet_to_ascii({spare_bits, d[7:6]}), 1'b0};
      pred_chars[1] = '{sextet_to_ascii(d[5:0]), l};
      n = 2;
      grp_pos = 2'd0;
      spare_bits = 4'd0;
    end else begin
      // position 0; the unused code 3 also starts a group
      pred_chars[0] = '{sextet_to_ascii(d[7:2]), 1'b0};
      if (l) begin
        pred_chars[1] = '{sextet_to_ascii({d[1:0], 4'b0000}), 1'b0};
        pred_chars[2] = '{CharPad, 1'b0};
        pred_chars[3] = '{CharPad, 1'b1};
        n = 4;
        grp_pos = 2'd0;
        spare_bits = 4'd0;
      end else begin
        n = 1;
        spare_bits = {2'b00, d[1:0]};
        grp_pos = 2'd1;
      end
    end
    return n;
  endfunction

  // Offers one byte word and returns at the edge that takes it. Gaps are
  // put in front of the word, driven at the falling edge like everything.
  task automatic send_byte(input logic [7:0] d, input logic l);
    while (!steady_run && $urandom_range(99) < 13) begin
      @(negedge clk_i);
      byte_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= d;
    byte_if.is_last   <= l;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
    if (l) msgs_sent++;
  endtask

  // random byte with a bias towards the all-zero and all-one extremes
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // out_o back-pressure, changed at the falling edge
  always @(negedge clk_i) begin
    char_if.ready <= steady_run || ($urandom_range(99) >= 13);
  end

  // out_o checker: each character word against the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && char_if.valid && char_if.ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character word %h eot %0b", $time,
                 char_if.out_char, char_if.end_of_text);
        fail_count++;
      end else begin
        exp_c = pending_chars.pop_front();
        chars_checked++;
        if (char_if.out_char !== exp_c.ch) begin
          $display("%0t: out_char expected %h actual %h", $time,
                   exp_c.ch, char_if.out_char);
          fail_count++;
        end
        if (char_if.end_of_text !== exp_c.eot) begin
          $display("%0t: end_of_text expected %0b actual %0b", $time,
                   exp_c.eot, char_if.end_of_text);
          fail_count++;
        end
      end
    end
  end

  // hard stop should the block hang
  initial begin
    #400000;
    $display("base64_stream_encoder_core verification failed");
    $finish;
  end

  initial begin
    int n;
    int msg_len;
    logic [7:0] d;
    logic [7:0] txt_c;

    byte_if.valid     = 1'b0;
    byte_if.data_byte = 8'h00;
    byte_if.is_last   = 1'b0;
    grp_pos       = 2'd0;
    spare_bits    = 4'd0;
    steady_run    = 1'b0;
    fail_count    = 0;
    bytes_sent    = 0;
    msgs_sent     = 0;
    chars_checked = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Typed rows queue the characters written in the table;
    // the model is still stepped so that its group position keeps up.
    foreach (DirRows[i]) begin
      send_byte(DirRows[i].data, DirRows[i].last);
      n = encode_byte(DirRows[i].data, DirRows[i].last);
      if (DirRows[i].typed) begin
        for (int k = 0; k < int'(DirRows[i].n_chars); k++) begin
          txt_c = DirRows[i].text[31-8*k -: 8];
          pending_chars.push_back('{txt_c[CharW-1:0],
                                    DirRows[i].last && (k == int'(DirRows[i].n_chars) - 1)});
        end
      end else begin
        for (int k = 0; k < n; k++) pending_chars.push_back(pred_chars[k]);
      end
    end

    // Random part: whole messages, mostly short so that every group
    // position is hit often as the final one, now and then a long one.
    while (bytes_sent < NumDir + RandBytes) begin
      msg_len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 9);
      for (int k = 0; k < msg_len; k++) begin
        steady_run = (bytes_sent >= SteadyLo) && (bytes_sent < SteadyHi);
        d = pick_byte();
        send_byte(d, k == msg_len - 1);
        n = encode_byte(d, k == msg_len - 1);
        for (int j = 0; j < n; j++) pending_chars.push_back(pred_chars[j]);
      end
    end
    steady_run = 1'b0;
    @(negedge clk_i);
    byte_if.valid <= 1'b0;

    // drain, then wait on to catch any stray characters
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Encoded %0d bytes in %0d messages; %0d characters compared, %0d mismatches.",
             bytes_sent, msgs_sent, chars_checked, fail_count);
    if (fail_count == 0) begin
      $display("base64_stream_encoder_core verification clean");
    end else begin
      $display("base64_stream_encoder_core verification failed");
    end
    $finish;
  end

endmodule
